### rtl/core/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types, constants and microcode encodings of the clamped PID core.
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned LIM_W     = 31;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned UC_ADDR_W = 4;
    localparam int unsigned DIV_BITS  = 31;
    localparam int unsigned CNT_W     = $clog2(DIV_BITS);

    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh0001_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN     = 3'd0,
        CFG_INTEGRAL_GAIN = 3'd1,
        CFG_DERIV_GAIN    = 3'd2,
        CFG_INTEG_LIMIT   = 3'd3,
        CFG_DRIVE_LIMIT   = 3'd4,
        CFG_MEAS_SCALE    = 3'd5,
        CFG_REF_SCALE     = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] prop_gain;
        logic signed [DATA_W-1:0] integral_gain;
        logic signed [DATA_W-1:0] deriv_gain;
        logic [LIM_W-1:0]         integ_limit;
        logic [LIM_W-1:0]         drive_limit;
        logic signed [DATA_W-1:0] meas_scale;
        logic signed [DATA_W-1:0] ref_scale;
    } t_cfg;

    // microcode step addresses
    typedef enum logic [UC_ADDR_W-1:0] {
        UC_MUL_MEAS  = 4'd0,
        UC_MUL_REF   = 4'd1,
        UC_ERR_SUM   = 4'd2,
        UC_ERR_WB    = 4'd3,
        UC_INC_MUL   = 4'd4,
        UC_INC_ADD   = 4'd5,
        UC_INTEG_WB  = 4'd6,
        UC_DIV_LOOP  = 4'd7,
        UC_DER       = 4'd8,
        UC_MUL_I     = 4'd9,
        UC_MUL_D     = 4'd10,
        UC_DRV_ADD   = 4'd11,
        UC_DRV_WB    = 4'd12,
        UC_CLEAR     = 4'd13
    } t_uc_addr;

    typedef enum logic [2:0] {
        MUL_NONE = 3'd0,
        MUL_MEAS = 3'd1,
        MUL_REF  = 3'd2,
        MUL_INC  = 3'd3,
        MUL_P    = 3'd4,
        MUL_I    = 3'd5,
        MUL_D    = 3'd6
    } t_mul_sel;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } t_acc_op;

    typedef enum logic [1:0] {
        SRC_PROD     = 2'd0,
        SRC_PROD_SAT = 2'd1,
        SRC_INTEG    = 2'd2
    } t_acc_src;

    typedef enum logic [3:0] {
        DP_NONE     = 4'd0,
        DP_WB_ERR   = 4'd1,
        DP_DIFF     = 4'd2,
        DP_DIV_LOAD = 4'd3,
        DP_DIV_STEP = 4'd4,
        DP_DER      = 4'd5,
        DP_WB_INTEG = 4'd6,
        DP_WB_DRIVE = 4'd7,
        DP_WB_CLEAR = 4'd8
    } t_dp_op;

    typedef enum logic [1:0] {
        JC_NEXT = 2'd0,
        JC_ZDT  = 2'd1,
        JC_LOOP = 2'd2,
        JC_DONE = 2'd3
    } t_jump;

    typedef struct packed {
        t_mul_sel               mul_sel;
        t_acc_op                acc_op;
        t_acc_src               acc_src;
        logic                   acc_neg;
        t_dp_op                 dp_op;
        t_jump                  jump;
        logic [UC_ADDR_W-1:0]   target;
    } t_ctrl;

    typedef struct packed {
        logic zero_dt;
    } t_status;

    typedef struct packed {
        logic busy;
        logic go;
        logic out_load;
    } t_seq;

endpackage

### rtl/core/pcc_ucode_rom.sv
// ----------------------------------------------------------------------------
// pcc_ucode_rom
// Control store: one control word per microcode step of the PID program.
// ----------------------------------------------------------------------------
module pcc_ucode_rom
    import pcc_pkg::*;
(
    input  logic [UC_ADDR_W-1:0] i_addr,
    output t_ctrl                o_ctrl
);

    function automatic t_ctrl uw(
        input t_mul_sel             m,
        input t_acc_op              a,
        input t_acc_src             s,
        input logic                 ng,
        input t_dp_op               d,
        input t_jump                j,
        input logic [UC_ADDR_W-1:0] tg
    );
        t_ctrl c;
        c.mul_sel = m;
        c.acc_op  = a;
        c.acc_src = s;
        c.acc_neg = ng;
        c.dp_op   = d;
        c.jump    = j;
        c.target  = tg;
        return c;
    endfunction

    always_comb begin
        unique case (i_addr)
            UC_MUL_MEAS: o_ctrl = uw(MUL_MEAS, ACC_HOLD, SRC_PROD, 1'b0, DP_NONE,
                                     JC_NEXT, UC_MUL_MEAS);
            UC_MUL_REF:  o_ctrl = uw(MUL_REF, ACC_LOAD, SRC_PROD_SAT, 1'b1, DP_NONE,
                                     JC_NEXT, UC_MUL_MEAS);
            UC_ERR_SUM:  o_ctrl = uw(MUL_NONE, ACC_ADD, SRC_PROD_SAT, 1'b0, DP_NONE,
                                     JC_NEXT, UC_MUL_MEAS);
            UC_ERR_WB:   o_ctrl = uw(MUL_NONE, ACC_HOLD, SRC_PROD, 1'b0, DP_WB_ERR,
                                     JC_NEXT, UC_MUL_MEAS);
            UC_INC_MUL:  o_ctrl = uw(MUL_INC, ACC_LOAD, SRC_INTEG, 1'b0, DP_DIFF,
                                     JC_NEXT, UC_MUL_MEAS);
            UC_INC_ADD:  o_ctrl = uw(MUL_NONE, ACC_ADD, SRC_PROD, 1'b0, DP_DIV_LOAD,
                                     JC_NEXT, UC_MUL_MEAS);
            UC_INTEG_WB: o_ctrl = uw(MUL_NONE, ACC_HOLD, SRC_PROD, 1'b0, DP_WB_INTEG,
                                     JC_ZDT, UC_DER);
            UC_DIV_LOOP: o_ctrl = uw(MUL_NONE, ACC_HOLD, SRC_PROD, 1'b0, DP_DIV_STEP,
                                     JC_LOOP, UC_DIV_LOOP);
            UC_DER:      o_ctrl = uw(MUL_P, ACC_HOLD, SRC_PROD, 1'b0, DP_DER,
                                     JC_NEXT, UC_MUL_MEAS);
            UC_MUL_I:    o_ctrl = uw(MUL_I, ACC_LOAD, SRC_PROD, 1'b0, DP_NONE,
                                     JC_NEXT, UC_MUL_MEAS);
            UC_MUL_D:    o_ctrl = uw(MUL_D, ACC_ADD, SRC_PROD, 1'b0, DP_NONE,
                                     JC_NEXT, UC_MUL_MEAS);
            UC_DRV_ADD:  o_ctrl = uw(MUL_NONE, ACC_ADD, SRC_PROD, 1'b0, DP_NONE,
                                     JC_NEXT, UC_MUL_MEAS);
            UC_DRV_WB:   o_ctrl = uw(MUL_NONE, ACC_HOLD, SRC_PROD, 1'b0, DP_WB_DRIVE,
                                     JC_DONE, UC_MUL_MEAS);
            UC_CLEAR:    o_ctrl = uw(MUL_NONE, ACC_HOLD, SRC_PROD, 1'b0, DP_WB_CLEAR,
                                     JC_DONE, UC_MUL_MEAS);
            default:     o_ctrl = uw(MUL_NONE, ACC_HOLD, SRC_PROD, 1'b0, DP_WB_CLEAR,
                                     JC_DONE, UC_MUL_MEAS);
        endcase
    end

endmodule

### rtl/core/pcc_sequencer.sv
// ----------------------------------------------------------------------------
// pcc_sequencer
// Step counter, divide loop counter and jump logic of the microcode engine.
// ----------------------------------------------------------------------------
module pcc_sequencer
    import pcc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_mode,
    input  t_ctrl                i_ctrl,
    input  t_status              i_status,
    input  logic                 i_out_free,
    output logic [UC_ADDR_W-1:0] o_pc,
    output t_seq                 o_seq
);

    logic                 r_busy;
    logic                 n_busy;
    logic [UC_ADDR_W-1:0] r_pc;
    logic [UC_ADDR_W-1:0] n_pc;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;
    logic                 go;
    logic                 done;

    assign done = (i_ctrl.jump == JC_DONE);
    assign go   = r_busy && (!done || i_out_free);

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_pc   = i_mode ? UC_CLEAR : UC_MUL_MEAS;
        end else if (go) begin
            unique case (i_ctrl.jump)
                JC_NEXT: n_pc = r_pc + 1'b1;
                JC_ZDT:  n_pc = i_status.zero_dt ? i_ctrl.target : r_pc + 1'b1;
                JC_LOOP: n_pc = (r_cnt != '0) ? i_ctrl.target : r_pc + 1'b1;
                JC_DONE: n_busy = 1'b0;
                default: n_busy = 1'b0;
            endcase
            if (i_ctrl.dp_op == DP_DIV_LOAD) begin
                n_cnt = CNT_W'(DIV_BITS - 1);
            end else if (i_ctrl.dp_op == DP_DIV_STEP && r_cnt != '0) begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= UC_MUL_MEAS;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
            r_cnt  <= n_cnt;
        end
    end

    assign o_pc           = r_pc;
    assign o_seq.busy     = r_busy;
    assign o_seq.go       = go;
    assign o_seq.out_load = go && done;

endmodule

### rtl/core/pcc_datapath.sv
// ----------------------------------------------------------------------------
// pcc_datapath
// Shared multiplier, accumulator, restoring divider and PID state registers.
// ----------------------------------------------------------------------------
module pcc_datapath
    import pcc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cap,
    input  logic signed [DATA_W-1:0] i_measurement,
    input  logic signed [DATA_W-1:0] i_reference,
    input  logic [LIM_W-1:0]         i_time_step,
    input  t_cfg                     i_cfg,
    input  t_ctrl                    i_ctrl,
    input  logic                     i_go,
    output t_status                  o_status,
    output logic signed [DATA_W-1:0] o_drive,
    output logic                     o_drive_clamped,
    output logic                     o_integ_clamped,
    output logic                     o_zero_step
);

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] val;
    } t_bnd;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [49:0] x);
        if (x[49:31] == '0 || x[49:31] == '1) begin
            return x[31:0];
        end
        return x[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    function automatic t_bnd bound(input logic signed [49:0] x, input logic [LIM_W-1:0] lim);
        logic signed [49:0] lim_p;
        logic signed [49:0] lim_n;
        t_bnd               b;
        lim_p = {19'b0, lim};
        lim_n = -lim_p;
        if (x > lim_p) begin
            b.hit = 1'b1;
            b.val = lim_p[31:0];
        end else if (x < lim_n) begin
            b.hit = 1'b1;
            b.val = lim_n[31:0];
        end else begin
            b.hit = 1'b0;
            b.val = x[31:0];
        end
        return b;
    endfunction

    logic signed [DATA_W-1:0] r_meas;
    logic signed [DATA_W-1:0] r_ref;
    logic [LIM_W-1:0]         r_dt;
    logic signed [47:0]       r_prod;
    logic signed [49:0]       r_acc;
    logic signed [49:0]       n_acc;
    logic signed [DATA_W-1:0] r_err;
    logic signed [DATA_W-1:0] r_der;
    logic signed [DATA_W-1:0] r_integ;
    logic signed [DATA_W-1:0] r_last;
    logic                     r_ihit;
    logic [32:0]              r_dmag;
    logic                     r_dneg;
    logic                     r_dovf;
    logic [LIM_W-1:0]         r_rem;
    logic [DIV_BITS-1:0]      r_quo;

    logic signed [32:0]       mul_a;
    logic signed [32:0]       mul_b;
    logic signed [65:0]       mul_full;
    logic signed [49:0]       prod_x;
    logic signed [49:0]       addend;
    logic signed [49:0]       addend_n;
    logic signed [32:0]       diff;
    logic [32:0]              dmag;
    logic [31:0]              trial;
    logic [31:0]              trial_sub;
    logic                     trial_ge;
    logic signed [DATA_W-1:0] quo_s;
    logic signed [DATA_W-1:0] der_n;
    logic                     zero_dt;
    t_bnd                     ibnd;
    t_bnd                     dbnd;

    // multiplier operand selection
    always_comb begin
        unique case (i_ctrl.mul_sel)
            MUL_MEAS: begin
                mul_a = {i_cfg.meas_scale[31], i_cfg.meas_scale};
                mul_b = {r_meas[31], r_meas};
            end
            MUL_REF: begin
                mul_a = {i_cfg.ref_scale[31], i_cfg.ref_scale};
                mul_b = {r_ref[31], r_ref};
            end
            MUL_INC: begin
                mul_a = {r_err[31], r_err};
                mul_b = {2'b00, r_dt};
            end
            MUL_P: begin
                mul_a = {i_cfg.prop_gain[31], i_cfg.prop_gain};
                mul_b = {r_err[31], r_err};
            end
            MUL_I: begin
                mul_a = {i_cfg.integral_gain[31], i_cfg.integral_gain};
                mul_b = {r_integ[31], r_integ};
            end
            MUL_D: begin
                mul_a = {i_cfg.deriv_gain[31], i_cfg.deriv_gain};
                mul_b = {r_der[31], r_der};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;
    assign prod_x   = {{2{r_prod[47]}}, r_prod};

    // accumulator
    always_comb begin
        unique case (i_ctrl.acc_src)
            SRC_PROD:     addend = prod_x;
            SRC_PROD_SAT: addend = 50'(sat32(prod_x));
            SRC_INTEG:    addend = 50'(r_integ);
            default:      addend = '0;
        endcase
        addend_n = i_ctrl.acc_neg ? -addend : addend;
        unique case (i_ctrl.acc_op)
            ACC_LOAD: n_acc = addend_n;
            ACC_ADD:  n_acc = r_acc + addend_n;
            default:  n_acc = r_acc;
        endcase
    end

    // error difference and divider step
    assign diff      = {r_err[31], r_err} - {r_last[31], r_last};
    assign dmag      = diff[32] ? 33'(-diff) : diff;
    assign trial     = {r_rem, r_quo[DIV_BITS-1]};
    assign trial_ge  = (trial >= {1'b0, r_dt});
    assign trial_sub = trial - {1'b0, r_dt};
    assign quo_s     = {1'b0, r_quo};
    assign zero_dt   = (r_dt == '0);

    always_comb begin
        if (zero_dt) begin
            der_n = '0;
        end else if (r_dovf) begin
            der_n = r_dneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            der_n = r_dneg ? -quo_s : quo_s;
        end
    end

    assign ibnd = bound(r_acc, i_cfg.integ_limit);
    assign dbnd = bound(r_acc, i_cfg.drive_limit);

    always_ff @(posedge i_clk) begin
        if (i_cap) begin
            r_meas <= i_measurement;
            r_ref  <= i_reference;
            r_dt   <= i_time_step;
        end
        if (i_go) begin
            if (i_ctrl.mul_sel != MUL_NONE) begin
                r_prod <= mul_full[63:16];
            end
            r_acc <= n_acc;
            unique case (i_ctrl.dp_op)
                DP_WB_ERR: r_err <= sat32(r_acc);
                DP_DIFF: begin
                    r_dneg <= diff[32];
                    r_dmag <= dmag;
                end
                DP_DIV_LOAD: begin
                    r_dovf <= ({15'b0, r_dmag} >= {2'b0, r_dt, 15'b0});
                    r_rem  <= {13'b0, r_dmag[32:15]};
                    r_quo  <= {r_dmag[14:0], 16'b0};
                end
                DP_DIV_STEP: begin
                    r_rem <= trial_ge ? trial_sub[LIM_W-1:0] : trial[LIM_W-1:0];
                    r_quo <= {r_quo[DIV_BITS-2:0], trial_ge};
                end
                DP_DER:      r_der  <= der_n;
                DP_WB_INTEG: r_ihit <= ibnd.hit;
                DP_WB_DRIVE: begin
                    o_drive         <= dbnd.val;
                    o_drive_clamped <= dbnd.hit;
                    o_integ_clamped <= r_ihit;
                    o_zero_step     <= zero_dt;
                end
                DP_WB_CLEAR: begin
                    o_drive         <= '0;
                    o_drive_clamped <= 1'b0;
                    o_integ_clamped <= 1'b0;
                    o_zero_step     <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_last  <= '0;
        end else if (i_go) begin
            if (i_ctrl.dp_op == DP_WB_INTEG) begin
                r_integ <= ibnd.val;
            end else if (i_ctrl.dp_op == DP_WB_DRIVE) begin
                r_last <= r_err;
            end else if (i_ctrl.dp_op == DP_WB_CLEAR) begin
                r_integ <= '0;
                r_last  <= '0;
            end
        end
    end

    assign o_status.zero_dt = zero_dt;

endmodule

### rtl/core/pid_controller_clamped.sv
// ----------------------------------------------------------------------------
// pid_controller_clamped
// Clamped Q16.16 PID controller run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// usage
//   input channel: i_valid / o_stall with mode, measurement, reference and
//   time step; one beat is one control step. output channel: o_valid /
//   i_stall with drive and the three flags, one beat per input beat.
//   config channel: i_cfg_valid / o_cfg_ready (always ready), write only
//   between steps; unknown indexes are dropped.
//   a control step runs 12 single microcode steps around one shared
//   33x33 multiplier plus the loop of the one-bit-per-cycle restoring
//   divider for the derivative. o_valid rises once the last step loads
//   the output register; the result beat and the next input beat can be
//   taken together, and no new step is accepted while one is running.
//   zero time step skips the divider; clear runs only its clear step.
//   o_stall is high from accept until the result moves into the output
//   register; while the receiver stalls a finished result, the engine
//   waits on its last step with o_stall high.
//   reset clears the integrator and previous error, loads the default
//   registers (gains 0, scales 1.0, limits full scale) and empties the
//   output register.
// ----------------------------------------------------------------------------
module pid_controller_clamped
    import pcc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_mode,
    input  logic signed [DATA_W-1:0] i_measurement,
    input  logic signed [DATA_W-1:0] i_reference,
    input  logic [LIM_W-1:0]         i_time_step,

    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [DATA_W-1:0] o_drive,
    output logic                     o_drive_clamped,
    output logic                     o_integ_clamped,
    output logic                     o_zero_step,

    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [DATA_W-1:0]        i_cfg_data
);

    t_cfg                 r_cfg;
    logic                 r_out_valid;
    logic                 out_free;
    logic                 in_beat;
    logic [UC_ADDR_W-1:0] pc;
    t_ctrl                ctrl;
    t_status              status;
    t_seq                 seq;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain     <= '0;
            r_cfg.integral_gain <= '0;
            r_cfg.deriv_gain    <= '0;
            r_cfg.integ_limit   <= '1;
            r_cfg.drive_limit   <= '1;
            r_cfg.meas_scale    <= Q_ONE;
            r_cfg.ref_scale     <= Q_ONE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PROP_GAIN:     r_cfg.prop_gain     <= i_cfg_data;
                CFG_INTEGRAL_GAIN: r_cfg.integral_gain <= i_cfg_data;
                CFG_DERIV_GAIN:    r_cfg.deriv_gain    <= i_cfg_data;
                CFG_INTEG_LIMIT:   r_cfg.integ_limit   <= i_cfg_data[LIM_W-1:0];
                CFG_DRIVE_LIMIT:   r_cfg.drive_limit   <= i_cfg_data[LIM_W-1:0];
                CFG_MEAS_SCALE:    r_cfg.meas_scale    <= i_cfg_data;
                CFG_REF_SCALE:     r_cfg.ref_scale     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_stall  = seq.busy;
    assign in_beat  = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq.out_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid = r_out_valid;

    pcc_ucode_rom u_rom (
        .i_addr (pc),
        .o_ctrl (ctrl)
    );

    pcc_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_beat),
        .i_mode     (i_mode),
        .i_ctrl     (ctrl),
        .i_status   (status),
        .i_out_free (out_free),
        .o_pc       (pc),
        .o_seq      (seq)
    );

    pcc_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cap           (in_beat),
        .i_measurement   (i_measurement),
        .i_reference     (i_reference),
        .i_time_step     (i_time_step),
        .i_cfg           (r_cfg),
        .i_ctrl          (ctrl),
        .i_go            (seq.go),
        .o_status        (status),
        .o_drive         (o_drive),
        .o_drive_clamped (o_drive_clamped),
        .o_integ_clamped (o_integ_clamped),
        .o_zero_step     (o_zero_step)
    );

    a_busy_after_beat: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> o_stall
    ) else $error("engine not busy after input beat");

    a_result_from_work: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall)
    ) else $error("result appeared without a step in progress");

    a_load_when_free: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        seq.out_load |-> (seq.busy && out_free)
    ) else $error("output register overwritten");

    a_clamp_at_limit: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_drive_clamped) |->
            (o_drive == {1'b0, r_cfg.drive_limit} ||
             32'(o_drive + {1'b0, r_cfg.drive_limit}) == 32'd0)
    ) else $error("clamped drive not at its limit");

endmodule

### verif/pid_controller_clamped_tb.sv
// ----------------------------------------------------------------------------
// pid_controller_clamped_tb
// Self-checking bench for the clamped Q16.16 PID controller. An in-bench
// predictor tracks the integrator, the previous error and the register set,
// computes the expected drive and flags for every accepted step, and compares
// them against each result beat in order. Stimulus runs a random warm-up,
// a directed set (saturation, zero and tiny time steps, clears), then random
// steps under several register settings including the extremes, with random
// gaps and stalls on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module pid_controller_clamped_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pcc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam longint SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint SAT_MIN = -64'sh0000_0000_8000_0000;
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam int unsigned DRAIN_CYCLES = 60;
    localparam int unsigned RANDOM_STEPS = 190;

    typedef enum int {SET_TUNED, SET_HIGH, SET_LOW, SET_RANDOM} t_setting_kind;

    typedef struct {
        logic                     mode;
        logic signed [DATA_W-1:0] measurement;
        logic signed [DATA_W-1:0] reference;
        logic [LIM_W-1:0]         time_step;
    } t_step;

    typedef struct {
        logic signed [DATA_W-1:0] drive;
        logic                     drive_clamped;
        logic                     integ_clamped;
        logic                     zero_step;
    } t_drive;

    class t_drive_tracker;
        logic signed [DATA_W-1:0] prop_gain;
        logic signed [DATA_W-1:0] integral_gain;
        logic signed [DATA_W-1:0] deriv_gain;
        logic signed [DATA_W-1:0] meas_scale;
        logic signed [DATA_W-1:0] ref_scale;
        logic [LIM_W-1:0]         integ_limit;
        logic [LIM_W-1:0]         drive_limit;
        longint                   integ_acc;
        longint                   prev_err;
        t_drive                   pending_drive[$];
        int unsigned              errors;
        int unsigned              n_steps;
        int unsigned              n_clears;
        int unsigned              n_zero_dt;
        int unsigned              n_checked;
        int unsigned              n_settings;

        function new();
            prop_gain     = '0;
            integral_gain = '0;
            deriv_gain    = '0;
            integ_limit   = '1;
            drive_limit   = '1;
            meas_scale    = Q_ONE;
            ref_scale     = Q_ONE;
            integ_acc     = 0;
            prev_err      = 0;
            errors        = 0;
            n_steps       = 0;
            n_clears      = 0;
            n_zero_dt     = 0;
            n_checked     = 0;
            n_settings    = 1;
        endfunction

        // q16.16 product, floor rounding
        function longint qmul(longint a, longint b);
            return (a * b) >>> FRAC_BITS;
        endfunction

        function longint sat32(longint x);
            if (x > SAT_MAX) return SAT_MAX;
            if (x < SAT_MIN) return SAT_MIN;
            return x;
        endfunction

        function longint clamp_to(longint x, longint lim, output logic hit);
            hit = 1'b1;
            if (x > lim) return lim;
            if (x < -lim) return -lim;
            hit = 1'b0;
            return x;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
            case (idx)
                CFG_PROP_GAIN:     prop_gain = data;
                CFG_INTEGRAL_GAIN: integral_gain = data;
                CFG_DERIV_GAIN:    deriv_gain = data;
                CFG_INTEG_LIMIT:   integ_limit = data[LIM_W-1:0];
                CFG_DRIVE_LIMIT:   drive_limit = data[LIM_W-1:0];
                CFG_MEAS_SCALE:    meas_scale = data;
                CFG_REF_SCALE:     ref_scale = data;
                default: ;
            endcase
        endfunction

        function void take_step(t_step s);
            t_drive want;
            longint sm, sr, err, der, drv, dt;
            logic   ihit, dhit;
            want = '{default: '0};
            n_steps++;
            if (s.mode) begin
                n_clears++;
                integ_acc = 0;
                prev_err  = 0;
            end else begin
                dt  = s.time_step;
                sm  = sat32(qmul(meas_scale, s.measurement));
                sr  = sat32(qmul(ref_scale, s.reference));
                err = sat32(sr - sm);
                if (dt == 0) begin
                    der = 0;
                    n_zero_dt++;
                end else begin
                    der = sat32(((err - prev_err) * Q_ONE) / dt);
                end
                integ_acc = clamp_to(integ_acc + qmul(err, dt), integ_limit, ihit);
                drv = qmul(prop_gain, err) + qmul(integral_gain, integ_acc)
                    + qmul(deriv_gain, der);
                drv = clamp_to(drv, drive_limit, dhit);
                prev_err = err;
                want.drive         = drv[DATA_W-1:0];
                want.drive_clamped = dhit;
                want.integ_clamped = ihit;
                want.zero_step     = (dt == 0);
            end
            pending_drive.push_back(want);
        endfunction

        function void check_drive(t_drive got);
            t_drive want;
            n_checked++;
            if (pending_drive.size() == 0) begin
                $error("result beat with nothing pending, drive %0d", got.drive);
                errors++;
                return;
            end
            want = pending_drive.pop_front();
            if (got.drive !== want.drive) begin
                $error("drive: expected %0d, got %0d", want.drive, got.drive);
                errors++;
            end
            if (got.drive_clamped !== want.drive_clamped) begin
                $error("drive_clamped: expected %0b, got %0b",
                       want.drive_clamped, got.drive_clamped);
                errors++;
            end
            if (got.integ_clamped !== want.integ_clamped) begin
                $error("integ_clamped: expected %0b, got %0b",
                       want.integ_clamped, got.integ_clamped);
                errors++;
            end
            if (got.zero_step !== want.zero_step) begin
                $error("zero_step: expected %0b, got %0b", want.zero_step, got.zero_step);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic                     i_mode = 1'b0;
    logic signed [DATA_W-1:0] i_measurement = '0;
    logic signed [DATA_W-1:0] i_reference = '0;
    logic [LIM_W-1:0]         i_time_step = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [DATA_W-1:0] o_drive;
    logic                     o_drive_clamped;
    logic                     o_integ_clamped;
    logic                     o_zero_step;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [DATA_W-1:0]        i_cfg_data = '0;

    bit calm = 1'b0;
    bit hold_req = 1'b0;
    t_drive_tracker tracker = new();

    pid_controller_clamped u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .i_measurement   (i_measurement),
        .i_reference     (i_reference),
        .i_time_step     (i_time_step),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_drive         (o_drive),
        .o_drive_clamped (o_drive_clamped),
        .o_integ_clamped (o_integ_clamped),
        .o_zero_step     (o_zero_step),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 30);
        return $urandom_range(40, 200);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: case ($urandom_range(0, 4))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return '0;
                3: return '1;
                default: return 32'h0000_0001;
            endcase
            1, 2: return $urandom();
            default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        endcase
    endfunction

    function automatic logic [LIM_W-1:0] pick_dt();
        case ($urandom_range(0, 19))
            0, 1: return '0;
            2: return '1;
            3: return LIM_W'($urandom());
            4: return 31'd1;
            default: return LIM_W'($urandom_range(1, 32'h0000_4000));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0: return pick_value();
            1: return $urandom();
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function automatic logic [LIM_W-1:0] pick_limit();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return LIM_W'($urandom());
            default: return LIM_W'($urandom_range(1, 32'h0100_0000));
        endcase
    endfunction

    task automatic send_step(t_step s);
        i_valid       <= 1'b1;
        i_mode        <= s.mode;
        i_measurement <= s.measurement;
        i_reference   <= s.reference;
        i_time_step   <= s.time_step;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.take_step(s);
    endtask

    task automatic pause_in(int unsigned n);
        if (n != 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending_drive.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.set_reg(idx, data);
    endtask

    task automatic load_settings(t_setting_kind kind);
        t_cfg_idx          idx;
        logic [DATA_W-1:0] data;
        bit                is_lim;
        for (int i = CFG_PROP_GAIN; i <= CFG_REF_SCALE; i++) begin
            idx    = t_cfg_idx'(i);
            is_lim = (idx == CFG_INTEG_LIMIT) || (idx == CFG_DRIVE_LIMIT);
            case (kind)
                SET_TUNED: case (idx) inside
                    CFG_PROP_GAIN, CFG_MEAS_SCALE, CFG_REF_SCALE: data = Q_ONE;
                    CFG_INTEGRAL_GAIN: data = Q_ONE >>> 1;
                    CFG_DERIV_GAIN:    data = Q_ONE >>> 2;
                    default:           data = 32'h0064_0000;
                endcase
                SET_HIGH: data = 32'h7FFF_FFFF;
                SET_LOW:  data = is_lim ? '0 : 32'h8000_0000;
                default:  data = is_lim ? {1'b0, pick_limit()} : pick_gain();
            endcase
            write_reg(idx, data);
        end
        // unmapped index must leave every register alone
        write_reg(CFG_SPARE, $urandom());
        i_cfg_valid <= 1'b0;
        tracker.n_settings++;
    endtask

    task automatic run_random(int unsigned n);
        t_step s;
        repeat (n) begin
            s.mode        = ($urandom_range(0, 24) == 0);
            s.measurement = pick_value();
            s.reference   = pick_value();
            s.time_step   = pick_dt();
            send_step(s);
            if ($urandom_range(0, 59) == 0) wait_drained();
            else if (!calm && $urandom_range(0, 2) == 0) pause_in(gap_len());
        end
    endtask

    task automatic run_directed();
        t_step list[$];
        list = '{
            '{1'b1, 32'sh0000_0000, 32'sh0000_0000, 31'h0000_0000},
            '{1'b0, 32'sh0001_0000, 32'sh0002_0000, 31'h0000_1000},
            '{1'b0, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF},
            '{1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF},
            '{1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h0000_0001},
            '{1'b0, 32'sh0000_0000, 32'sh0000_0000, 31'h0000_0000},
            '{1'b0, 32'sh0003_0000, 32'sh0000_0000, 31'h0000_0000},
            '{1'b0, 32'sh0000_0000, 32'sh0005_0000, 31'h0000_0001},
            '{1'b0, 32'shFFFF_FFFF, 32'sh0000_0001, 31'h0000_0001},
            '{1'b1, 32'sh1234_5678, 32'sh8765_4321, 31'h7FFF_FFFF},
            '{1'b0, 32'sh0000_0000, 32'sh0001_0000, 31'h0001_0000},
            '{1'b0, 32'sh0000_0000, 32'sh0040_0000, 31'h0001_0000},
            '{1'b0, 32'sh0000_0000, 32'sh0040_0000, 31'h0001_0000},
            '{1'b0, 32'sh0000_0000, 32'shFFC0_0000, 31'h0004_0000},
            '{1'b0, 32'sh0000_0000, 32'shFFC0_0000, 31'h0004_0000},
            '{1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h0000_0000},
            '{1'b0, 32'sh0000_0000, 32'sh0000_0000, 31'h0001_0000},
            '{1'b0, 32'shFFFF_0000, 32'sh0000_0000, 31'h0000_0001},
            '{1'b0, 32'sh0000_8000, 32'shFFFF_8000, 31'h0000_0003},
            '{1'b0, 32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF}
        };
        foreach (list[k]) begin
            send_step(list[k]);
            if (k % 3 == 2) pause_in(k);
        end
    endtask

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_random(30);
        wait_drained();
        load_settings(SET_TUNED);
        run_directed();
        wait_drained();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       load_settings(SET_HIGH);
                1:       load_settings(SET_LOW);
                default: load_settings(SET_RANDOM);
            endcase
            calm = (phase == 4);
            // long output hold-off while the sender keeps offering
            if (phase == 3) hold_req = 1'b1;
            run_random(RANDOM_STEPS);
            wait_drained();
        end
        calm = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d control steps (%0d clears, %0d zero time steps) over %0d settings",
                 tracker.n_steps, tracker.n_clears, tracker.n_zero_dt, tracker.n_settings);
        $display("checked %0d result beats, %0d-cycle output hold-off, %0d failures",
                 tracker.n_checked, HOLD_CYCLES, tracker.errors);
        if (tracker.errors == 0) begin
            $display("pid_controller_clamped: match");
        end else begin
            $display("pid_controller_clamped: mismatch");
        end
        $finish;
    end

    initial begin : result_sink
        t_drive      got;
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left  = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                got.drive         = o_drive;
                got.drive_clamped = o_drive_clamped;
                got.integ_clamped = o_integ_clamped;
                got.zero_step     = o_zero_step;
                tracker.check_drive(got);
            end
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                i_stall <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                if (!calm && $urandom_range(0, 3) == 0) stall_left = gap_len();
            end
        end
    end

    initial begin : watchdog
        #40_000_000;
        $display("pid_controller_clamped: mismatch");
        $finish;
    end

endmodule

### filelist.f
rtl/core/pcc_pkg.sv
rtl/core/pcc_ucode_rom.sv
rtl/core/pcc_sequencer.sv
rtl/core/pcc_datapath.sv
rtl/core/pid_controller_clamped.sv
verif/pid_controller_clamped_tb.sv
